FILE: rtl/iirl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirl_pkg: shared types and constants for the indexed insert/remove list
// Command and status codes, field widths and the control word that the list
// controller broadcasts to every storage cell.
// ----------------------------------------------------------------------------
package iirl_pkg;

    // Default list depth
    localparam int DEPTH_DEF = 64;

    // Fixed field widths
    localparam int CMD_W   = 3;
    localparam int POS_W   = 7;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCNT_W  = 7;
    localparam int IN_TDATA_W  = 48;   // 42 bits of fields, padded to bytes
    localparam int OUT_TDATA_W = 48;   // 41 bits of fields, padded to bytes

    // Command codes
    localparam logic [CMD_W-1:0] CMD_INSERT   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_GET      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PUSHBACK = 3'd3;
    localparam logic [CMD_W-1:0] CMD_POPBACK  = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Broadcast control to the cell chain
    typedef struct packed {
        logic ins;   // open a gap at the position, write the new word there
        logic rem;   // close the gap at the position
    } t_cell_ctl;

endpackage
`default_nettype wire

FILE: rtl/iirl_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// iirl_cell: one storage place of the list
// Holds one word. On insert it takes its lower neighbour's word (or the new
// word at the insert place); on remove it takes its upper neighbour's word.
// Presents its word on the read bus when its index matches the position.
// ----------------------------------------------------------------------------
module iirl_cell #(
    parameter int AW  = 6,
    parameter int IDX = 0
) (
    input  wire logic                        i_clk,
    input  wire iirl_pkg::t_cell_ctl         i_ctl,
    input  wire logic [AW-1:0]               i_pos,
    input  wire logic [iirl_pkg::WORD_W-1:0] i_value,
    input  wire logic [iirl_pkg::WORD_W-1:0] i_lower,
    input  wire logic [iirl_pkg::WORD_W-1:0] i_upper,
    output logic      [iirl_pkg::WORD_W-1:0] o_word,
    output logic      [iirl_pkg::WORD_W-1:0] o_rd
);
    import iirl_pkg::*;

    localparam logic [AW-1:0] MY_IDX = AW'(IDX);

    logic [WORD_W-1:0] r_word;
    logic [WORD_W-1:0] n_word;
    logic              w_hit;
    logic              w_above;

    assign w_hit   = (MY_IDX == i_pos);
    assign w_above = (MY_IDX > i_pos);

    // next word: shift up, load, shift down or hold
    always_comb begin
        n_word = r_word;
        if (i_ctl.ins) begin
            if (w_above) begin
                n_word = i_lower;
            end else if (w_hit) begin
                n_word = i_value;
            end
        end else if (i_ctl.rem) begin
            if (w_above || w_hit) begin
                n_word = i_upper;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    assign o_word = r_word;
    assign o_rd   = w_hit ? r_word : '0;

endmodule
`default_nettype wire

FILE: rtl/indexed_insert_remove_list_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_insert_remove_list_top: bounded ordered list with indexed access
// Holds up to DEPTH signed 32-bit words in a chain of cells and runs one
// command per word: insert at index, remove at index, get, push back, pop back.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on the s_axis channel, one word each; results leave on the
//   m_axis channel, one word per command, in command order.
//   A command is decoded, checked against the fill count and applied to all
//   cells in the cycle it is accepted; every cell shifts in parallel with its
//   neighbour, so there is no per-entry loop.
//   The result is valid in the cycle after acceptance.
//   Throughput: one command per cycle while m_axis_tready is high, set by the
//   single output register which is refilled in the same cycle it is drained.
//   Stall: while a result waits and m_axis_tready is low, s_axis_tready is
//   low; the result and the list hold.
//   Reset (i_rst_n low, synchronous): the fill count and the output valid are
//   cleared; the cell words are left as they are, as no place at or above the
//   count is ever read.
//   data is zero on any status other than ok, and on insert and push back.
//   count is the fill count after the command, in 7 bits.
// ----------------------------------------------------------------------------
module indexed_insert_remove_list_top #(
    parameter int DEPTH = iirl_pkg::DEPTH_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // command: [2:0] command, [9:3] position, [41:10] value, [47:42] zero
    input  wire logic [iirl_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // result: [1:0] status, [33:2] data, [40:34] count, [47:41] zero
    output logic      [iirl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready
);
    import iirl_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (CW > POS_W) ? CW : POS_W;
    localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);

    // input fields
    logic [CMD_W-1:0]  w_cmd;
    logic [POS_W-1:0]  w_position;
    logic [WORD_W-1:0] w_value;
    logic              w_acc;

    assign w_cmd      = s_axis_tdata[2:0];
    assign w_position = s_axis_tdata[9:3];
    assign w_value    = s_axis_tdata[41:10];

    // state
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_valid;
    logic [STAT_W-1:0] r_status;
    logic [STAT_W-1:0] n_status;
    logic [WORD_W-1:0] r_data;
    logic [WORD_W-1:0] n_data;
    logic [CW-1:0]     r_ocount;

    // decode
    t_cell_ctl         w_ctl;
    logic [PW-1:0]     w_pos_p;
    logic [PW-1:0]     w_cnt_p;
    logic [PW-1:0]     w_eff_p;
    logic [AW-1:0]     w_eff;
    logic              w_full;
    logic              w_empty;
    logic              w_read;
    logic [WORD_W-1:0] w_rd_bus;

    assign s_axis_tready = !r_valid || m_axis_tready;
    assign w_acc         = s_axis_tvalid && s_axis_tready;

    assign w_pos_p = PW'(w_position);
    assign w_cnt_p = PW'(r_count);
    assign w_full  = (w_cnt_p >= DEPTH_P);
    assign w_empty = (r_count == '0);

    // command check and effect
    always_comb begin
        w_ctl    = '0;
        w_eff_p  = w_pos_p;
        w_read   = 1'b0;
        n_status = ST_RANGE;
        n_count  = r_count;
        case (w_cmd)
            CMD_INSERT: begin
                if (w_pos_p > w_cnt_p) begin
                    n_status = ST_RANGE;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status  = ST_OK;
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (w_pos_p >= w_cnt_p) begin
                    n_status = ST_RANGE;
                end else begin
                    n_status  = ST_OK;
                    w_ctl.rem = 1'b1;
                    w_read    = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            CMD_GET: begin
                if (w_pos_p >= w_cnt_p) begin
                    n_status = ST_RANGE;
                end else begin
                    n_status = ST_OK;
                    w_read   = 1'b1;
                end
            end
            CMD_PUSHBACK: begin
                w_eff_p = w_cnt_p;
                if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status  = ST_OK;
                    w_ctl.ins = 1'b1;
                    n_count   = r_count + 1'b1;
                end
            end
            CMD_POPBACK: begin
                w_eff_p = w_cnt_p - 1'b1;
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status  = ST_OK;
                    w_ctl.rem = 1'b1;
                    w_read    = 1'b1;
                    n_count   = r_count - 1'b1;
                end
            end
            default: begin
                n_status = ST_RANGE;
            end
        endcase
        if (!w_acc) begin
            w_ctl = '0;
        end
    end

    assign w_eff  = AW'(w_eff_p);
    assign n_data = w_read ? w_rd_bus : '0;

    // cell chain
    logic [WORD_W-1:0] w_word [DEPTH];
    logic [WORD_W-1:0] w_rd   [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic [WORD_W-1:0] w_lower;
        logic [WORD_W-1:0] w_upper;
        if (g == 0) begin : g_first
            assign w_lower = w_word[g];
        end else begin : g_mid_lo
            assign w_lower = w_word[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_upper = w_word[g];
        end else begin : g_mid_hi
            assign w_upper = w_word[g+1];
        end
        iirl_cell #(
            .AW  (AW),
            .IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl),
            .i_pos   (w_eff),
            .i_value (w_value),
            .i_lower (w_lower),
            .i_upper (w_upper),
            .o_word  (w_word[g]),
            .o_rd    (w_rd[g])
        );
    end

    // read bus: only the matching cell drives a non-zero word
    always_comb begin
        w_rd_bus = '0;
        for (int k = 0; k < DEPTH; k++) begin
            w_rd_bus = w_rd_bus | w_rd[k];
        end
    end

    // fill count and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
                r_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_status <= n_status;
            r_data   <= n_data;
            r_ocount <= n_count;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {7'd0, OCNT_W'(r_ocount), r_data, r_status};

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("fill count above depth");

    a_grow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && n_status == ST_OK && (w_cmd == CMD_INSERT || w_cmd == CMD_PUSHBACK)
        |=> r_count == $past(r_count) + 1'b1)
        else $error("successful insert did not grow the list");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_status != ST_OK |-> r_data == '0)
        else $error("data not zero on error status");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> r_count == $past(r_count))
        else $error("fill count moved without a command");

endmodule
`default_nettype wire
